// File: design/relay_response_time_tester_top_macros.svh
// Assertion macros for the relay response time tester RTL.
// Depends on nothing; the including module provides clk and rst.
`ifndef RELAY_RESPONSE_TIME_TESTER_TOP_MACROS_SVH
`define RELAY_RESPONSE_TIME_TESTER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RRTT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RRTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/rrtt_pkg.sv
// Package for the relay response time tester: phase codes, register indexes
// and the result record. Used by every module of the block.
`default_nettype none

package rrtt_pkg;

  typedef enum logic [2:0] {
    PH_START,
    PH_WAIT,
    PH_ON_PAUSE,
    PH_OFF_PAUSE,
    PH_FINISHED
  } phase_t;

  localparam logic [1:0] REG_ON_PAUSE  = 2'd0;
  localparam logic [1:0] REG_OFF_PAUSE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;

  localparam logic [15:0] ON_PAUSE_RESET  = 16'd300;
  localparam logic [15:0] OFF_PAUSE_RESET = 16'd1000;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;

  localparam logic [15:0] TICK_MAX = 16'hFFFF;
  localparam logic [7:0]  DONE_MAX = 8'hFF;
  localparam logic [23:0] SUM_MAX  = 24'hFFFFFF;

  typedef struct packed {
    logic [22:0] average_x100;
    logic [23:0] total_ms;
    logic        finished;
    logic        already_closed;
    logic        timed_out;
    logic [7:0]  sample_number;
    logic [15:0] sample_delay_ms;
    logic        sample_valid;
    logic        relay_on;
  } res_t;

endpackage

`default_nettype wire

// File: design/rrtt_seq.sv
// Test sequencer: configuration registers, phase machine, counters and the
// first result register. Depends on rrtt_pkg and the assertion macro header.
`default_nettype none

`include "relay_response_time_tester_top_macros.svh"

module rrtt_seq
  import rrtt_pkg::*;
#(
  parameter int MEASUREMENT_COUNT = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic        adv,
  input  wire logic        contact,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  output res_t             res
);

  localparam logic [7:0] COUNT = 8'(MEASUREMENT_COUNT);

  logic [15:0] on_pause_ms;
  logic [15:0] off_pause_ms;
  logic [15:0] timeout_ms;

  phase_t      phase, phase_next;
  logic [7:0]  done_count, done_count_next;
  logic [15:0] elapsed_ticks, elapsed_ticks_next;
  logic [15:0] pause_ticks, pause_ticks_next;
  logic        prev_contact;
  logic [23:0] delay_sum, delay_sum_next;
  logic        relay_state, relay_state_next;

  logic        close_edge;
  logic [15:0] elapsed_inc;
  logic [15:0] pause_inc;
  logic [24:0] sum_wide;
  logic        capture;
  logic        timeout_hit;
  logic        finish_hit;
  logic        closed_hit;
  res_t        res_comb;

  assign close_edge  = contact && !prev_contact;
  assign elapsed_inc = (elapsed_ticks == TICK_MAX) ? TICK_MAX : elapsed_ticks + 16'd1;
  assign pause_inc   = (pause_ticks == TICK_MAX) ? TICK_MAX : pause_ticks + 16'd1;
  assign sum_wide    = {1'b0, delay_sum} + {9'b0, elapsed_inc};

  assign capture     = (phase == PH_WAIT) && close_edge;
  assign timeout_hit = (phase == PH_WAIT) && !close_edge &&
                       ((elapsed_inc > timeout_ms) || (elapsed_inc == TICK_MAX));
  assign finish_hit  = (phase == PH_START) && (done_count >= COUNT);
  assign closed_hit  = (phase == PH_START) && !finish_hit && contact;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_pause_ms  <= ON_PAUSE_RESET;
      off_pause_ms <= OFF_PAUSE_RESET;
      timeout_ms   <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_ON_PAUSE:  on_pause_ms  <= cfg_wdata;
        REG_OFF_PAUSE: off_pause_ms <= cfg_wdata;
        REG_TIMEOUT:   timeout_ms   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next         = phase;
    done_count_next    = done_count;
    elapsed_ticks_next = elapsed_ticks;
    pause_ticks_next   = pause_ticks;
    delay_sum_next     = delay_sum;
    relay_state_next   = relay_state;
    case (phase)
      PH_START: begin
        if (finish_hit) begin
          relay_state_next = 1'b0;
          phase_next       = PH_FINISHED;
        end else if (contact) begin
          relay_state_next = 1'b0;
          pause_ticks_next = 16'd0;
          phase_next       = PH_OFF_PAUSE;
        end else begin
          elapsed_ticks_next = 16'd0;
          relay_state_next   = 1'b1;
          phase_next         = PH_WAIT;
        end
      end
      PH_WAIT: begin
        elapsed_ticks_next = elapsed_inc;
        if (capture) begin
          delay_sum_next   = sum_wide[24] ? SUM_MAX : sum_wide[23:0];
          done_count_next  = (done_count == DONE_MAX) ? DONE_MAX : done_count + 8'd1;
          pause_ticks_next = 16'd0;
          phase_next       = PH_ON_PAUSE;
        end else if (timeout_hit) begin
          relay_state_next = 1'b0;
          pause_ticks_next = 16'd0;
          phase_next       = PH_OFF_PAUSE;
        end
      end
      PH_ON_PAUSE: begin
        if (pause_inc >= on_pause_ms) begin
          relay_state_next = 1'b0;
          pause_ticks_next = 16'd0;
          phase_next       = PH_OFF_PAUSE;
        end else begin
          pause_ticks_next = pause_inc;
        end
      end
      PH_OFF_PAUSE: begin
        pause_ticks_next = pause_inc;
        if (pause_inc >= off_pause_ms) begin
          phase_next = PH_START;
        end
      end
      default: begin
        relay_state_next = 1'b0;
        phase_next       = PH_FINISHED;
      end
    endcase
  end

  always_comb begin
    res_comb                 = '0;
    res_comb.relay_on        = relay_state_next;
    res_comb.sample_valid    = capture;
    res_comb.sample_delay_ms = capture ? elapsed_inc : 16'd0;
    res_comb.sample_number   = capture ? done_count : 8'd0;
    res_comb.timed_out       = timeout_hit;
    res_comb.already_closed  = closed_hit;
    res_comb.finished        = finish_hit;
    res_comb.total_ms        = finish_hit ? delay_sum : 24'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      done_count    <= 8'd0;
      elapsed_ticks <= 16'd0;
      pause_ticks   <= 16'd0;
      prev_contact  <= 1'b0;
      delay_sum     <= 24'd0;
      relay_state   <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      done_count    <= done_count_next;
      elapsed_ticks <= elapsed_ticks_next;
      pause_ticks   <= pause_ticks_next;
      prev_contact  <= contact;
      delay_sum     <= delay_sum_next;
      relay_state   <= relay_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_comb;
    end
  end

  `RRTT_ASSERT_SAME(a_capture_beats_timeout, capture, !timeout_hit, "capture and timeout together")
  `RRTT_ASSERT_SAME(a_count_bounded, 1'b1, done_count <= COUNT, "capture count beyond target")
  `RRTT_ASSERT_SAME(a_finished_relay_off, phase == PH_FINISHED, !relay_state, "relay on when finished")
  `RRTT_ASSERT_NEXT(a_capture_to_on_pause, take && capture, phase == PH_ON_PAUSE, "capture left no on pause")

endmodule

`default_nettype wire

// File: design/rrtt_avg.sv
// Average pipeline: total times 100 divided by the measurement count through a
// reciprocal multiply with one correction step, carrying the result alongside.
// Depends on rrtt_pkg.
`default_nettype none

module rrtt_avg
  import rrtt_pkg::*;
#(
  parameter int MEASUREMENT_COUNT = 10
) (
  input  wire logic clk,
  input  wire logic adv,
  input  res_t      res_in,
  output res_t      res_out
);

  localparam logic [7:0]  COUNT = 8'(MEASUREMENT_COUNT);
  localparam logic [31:0] RECIP = 32'((64'd1 << 31) / MEASUREMENT_COUNT);

  res_t        r1, r2, r3;
  logic [30:0] p1, p2, p3;
  logic [47:0] prod_lo;
  logic [46:0] prod_hi;
  logic [62:0] prod_sum;
  logic [22:0] q_est;
  logic [30:0] rem;
  logic [22:0] q_fix;
  res_t        res_fix;

  assign prod_sum = {prod_hi, 16'b0} + {15'b0, prod_lo};
  assign rem      = p3 - (31'(q_est) * 31'(COUNT));
  assign q_fix    = (rem >= 31'(COUNT)) ? q_est + 23'd1 : q_est;

  always_comb begin
    res_fix              = r3;
    res_fix.average_x100 = q_fix;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1      <= res_in;
      p1      <= {7'b0, res_in.total_ms} * 31'd100;
      r2      <= r1;
      p2      <= p1;
      prod_lo <= 48'(p1[15:0]) * 48'(RECIP);
      prod_hi <= 47'(p1[30:16]) * 47'(RECIP);
      r3      <= r2;
      p3      <= p2;
      q_est   <= prod_sum[53:31];
      res_out <= res_fix;
    end
  end

endmodule

`default_nettype wire

// File: design/relay_response_time_tester_top.sv
// Top level of the relay response time tester: stream handshake, stage valid
// bits and beat packing. Depends on rrtt_pkg, rrtt_seq and rrtt_avg.
//
//   Channel   Dir  Beat contents (lowest bit first)
//   s_*       in   contact_closed
//   m_*       out  relay_on .. average_x100, one result per tick
//   cfg_*     in   register index and 16-bit value, no read-back
//
// One tick is taken per clock cycle while the output is not stalled.
// The five stages are the sequencer register and four average stages, which
// include two multiplier stages over a split product.
// Reset is synchronous on rst and returns control state and config registers to defaults.
// A stalled output halts every stage together, so s_tready follows the output stage.
`default_nettype none

module relay_response_time_tester_top
  import rrtt_pkg::*;
#(
  parameter int MEASUREMENT_COUNT = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // contact_closed, then zero padding
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // relay_on, sample_valid, sample_delay_ms,
                                      // sample_number, timed_out, already_closed,
                                      // finished, total_ms, average_x100, padding
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  localparam int STAGES = 5;

  logic [STAGES-1:0] stage_valid;
  logic              adv;
  logic              take;
  res_t              seq_res;
  res_t              out_res;

  assign adv      = !stage_valid[STAGES-1] || m_tready;
  assign take     = s_tvalid && adv;
  assign s_tready = adv;
  assign m_tvalid = stage_valid[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (adv) begin
      stage_valid <= {stage_valid[STAGES-2:0], take};
    end
  end

  rrtt_seq #(
    .MEASUREMENT_COUNT(MEASUREMENT_COUNT)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .adv       (adv),
    .contact   (s_tdata[0]),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .res       (seq_res)
  );

  rrtt_avg #(
    .MEASUREMENT_COUNT(MEASUREMENT_COUNT)
  ) u_avg (
    .clk     (clk),
    .adv     (adv),
    .res_in  (seq_res),
    .res_out (out_res)
  );

  assign m_tdata = {4'b0, out_res};

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for relay_response_time_tester_top: one tick per input beat,
// with each result beat compared against an in-bench sequencer model or directed values.
// Depends on rrtt_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module testbench
  import rrtt_pkg::*;
();

  localparam int MEAS_COUNT = 10;
  localparam int PIPE_DEPTH = 5;
  localparam int STALL_LIMIT = 2000;
  localparam logic [1:0] REG_NONE = 2'd3;

  typedef enum logic [1:0] {ROW_TICK, ROW_CHECK, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {GEN_NOISY, GEN_HOLD_OPEN, GEN_CLOSE_SOON} contact_style_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  addr;
    logic [15:0] value;
    res_t        want;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_addr = 2'd0;
  logic [15:0] cfg_wdata = 16'd0;

  // Model of the sequencer and its registers.
  phase_t      exp_phase = PH_START;
  logic [7:0]  exp_done = 8'd0;
  logic [15:0] exp_elapsed = 16'd0;
  logic [15:0] exp_pause = 16'd0;
  logic        exp_prev = 1'b0;
  logic [23:0] exp_sum = 24'd0;
  logic        exp_relay = 1'b0;
  logic [15:0] exp_on_ms = ON_PAUSE_RESET;
  logic [15:0] exp_off_ms = OFF_PAUSE_RESET;
  logic [15:0] exp_limit_ms = TIMEOUT_RESET;

  res_t        pending_results[$];
  step_row_t   directed_rows[$];
  int          mismatches = 0;
  int          timeouts_predicted = 0;
  bit          series_over = 1'b0;
  bit          idle_on = 1'b1;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  relay_response_time_tester_top #(.MEASUREMENT_COUNT(MEAS_COUNT)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] bump_sat(input logic [15:0] v);
    return (v == TICK_MAX) ? TICK_MAX : v + 16'd1;
  endfunction

  task automatic predict_tick(input logic c, output res_t r);
    logic        closing;
    logic [24:0] grown;
    r = '0;
    closing = c && !exp_prev;
    case (exp_phase)
      PH_START: begin
        if (exp_done >= MEAS_COUNT) begin
          exp_relay = 1'b0;
          exp_phase = PH_FINISHED;
          r.finished = 1'b1;
          r.total_ms = exp_sum;
          r.average_x100 = 23'((64'(exp_sum) * 64'd100) / MEAS_COUNT);
        end else if (c) begin
          exp_relay = 1'b0;
          exp_pause = 16'd0;
          exp_phase = PH_OFF_PAUSE;
          r.already_closed = 1'b1;
        end else begin
          exp_elapsed = 16'd0;
          exp_relay = 1'b1;
          exp_phase = PH_WAIT;
        end
      end
      PH_WAIT: begin
        exp_elapsed = bump_sat(exp_elapsed);
        if (closing) begin
          r.sample_valid = 1'b1;
          r.sample_delay_ms = exp_elapsed;
          r.sample_number = exp_done;
          grown = 25'(exp_sum) + 25'(exp_elapsed);
          exp_sum = (grown > 25'(SUM_MAX)) ? SUM_MAX : grown[23:0];
          if (exp_done != DONE_MAX) exp_done = exp_done + 8'd1;
          exp_pause = 16'd0;
          exp_phase = PH_ON_PAUSE;
        end else if (exp_elapsed > exp_limit_ms || exp_elapsed == TICK_MAX) begin
          r.timed_out = 1'b1;
          exp_relay = 1'b0;
          exp_pause = 16'd0;
          exp_phase = PH_OFF_PAUSE;
        end
      end
      PH_ON_PAUSE: begin
        exp_pause = bump_sat(exp_pause);
        if (exp_pause >= exp_on_ms) begin
          exp_relay = 1'b0;
          exp_pause = 16'd0;
          exp_phase = PH_OFF_PAUSE;
        end
      end
      PH_OFF_PAUSE: begin
        exp_pause = bump_sat(exp_pause);
        if (exp_pause >= exp_off_ms) exp_phase = PH_START;
      end
      default: begin
        exp_relay = 1'b0;
        exp_phase = PH_FINISHED;
      end
    endcase
    exp_prev = c;
    r.relay_on = exp_relay;
  endtask

  // Chooses the contact level of the next tick from the phase the model is in.
  function automatic logic pick_contact(input contact_style_t style);
    case (exp_phase)
      PH_START:
        return (style == GEN_HOLD_OPEN) ? 1'b0 : ($urandom_range(0, 4) == 0);
      PH_WAIT: begin
        if (style == GEN_HOLD_OPEN) return 1'b0;
        if (style == GEN_CLOSE_SOON) return $urandom_range(0, 2) == 0;
        return (exp_done < MEAS_COUNT - 1) && ($urandom_range(0, 39) == 0);
      end
      PH_ON_PAUSE:
        return (style == GEN_NOISY) ? ($urandom_range(0, 7) != 0) : 1'b1;
      PH_OFF_PAUSE:
        return (style == GEN_NOISY) ? ($urandom_range(0, 7) == 0) : 1'b0;
      default:
        return 1'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic send_tick(input logic c, input logic typed_ok, input res_t typed);
    res_t r;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, c};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_tick(c, r);
    if (r.timed_out) timeouts_predicted++;
    if (r.finished) series_over = 1'b1;
    pending_results.push_back(typed_ok ? typed : r);
  endtask

  task automatic settle;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (addr)
      REG_ON_PAUSE:  exp_on_ms = value;
      REG_OFF_PAUSE: exp_off_ms = value;
      REG_TIMEOUT:   exp_limit_ms = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] on_ms, off_ms, limit_ms);
    settle();
    write_reg(REG_ON_PAUSE, on_ms);
    write_reg(REG_OFF_PAUSE, off_ms);
    write_reg(REG_TIMEOUT, limit_ms);
  endtask

  task automatic add_tick(input logic c);
    step_row_t row;
    row = '0;
    row.kind = ROW_TICK;
    row.value = {15'd0, c};
    directed_rows.push_back(row);
  endtask

  task automatic add_check(input logic c, relay, valid, input logic [15:0] delay,
                           input logic [7:0] number, input logic tmo, closed);
    step_row_t row;
    row = '0;
    row.kind = ROW_CHECK;
    row.value = {15'd0, c};
    row.want.relay_on = relay;
    row.want.sample_valid = valid;
    row.want.sample_delay_ms = delay;
    row.want.sample_number = number;
    row.want.timed_out = tmo;
    row.want.already_closed = closed;
    directed_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [1:0] addr, input logic [15:0] value);
    step_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.addr = addr;
    row.value = value;
    directed_rows.push_back(row);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch_results
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[75:0];
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none expected, got %h", $time, got);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("relay_on", 32'(want.relay_on), 32'(got.relay_on));
        check_field("sample_valid", 32'(want.sample_valid), 32'(got.sample_valid));
        check_field("sample_delay_ms", 32'(want.sample_delay_ms),
                    32'(got.sample_delay_ms));
        check_field("sample_number", 32'(want.sample_number), 32'(got.sample_number));
        check_field("timed_out", 32'(want.timed_out), 32'(got.timed_out));
        check_field("already_closed", 32'(want.already_closed),
                    32'(got.already_closed));
        check_field("finished", 32'(want.finished), 32'(got.finished));
        check_field("total_ms", 32'(want.total_ms), 32'(got.total_ms));
        check_field("average_x100", 32'(want.average_x100), 32'(got.average_x100));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    add_check(1'b1, 1'b0, 1'b0, 16'd0, 8'd0, 1'b0, 1'b1);
    add_cfg(REG_ON_PAUSE, 16'd1);
    add_cfg(REG_OFF_PAUSE, 16'd1);
    add_cfg(REG_TIMEOUT, 16'd2);
    add_cfg(REG_NONE, 16'hFFFF);
    add_tick(1'b0);
    add_check(1'b0, 1'b1, 1'b0, 16'd0, 8'd0, 1'b0, 1'b0);
    add_tick(1'b0);
    add_check(1'b1, 1'b1, 1'b1, 16'd2, 8'd0, 1'b0, 1'b0);
    add_tick(1'b1);
    add_tick(1'b1);
    add_check(1'b1, 1'b0, 1'b0, 16'd0, 8'd0, 1'b0, 1'b1);
    add_tick(1'b0);
    add_tick(1'b0);
    add_tick(1'b0);
    add_tick(1'b0);
    add_check(1'b0, 1'b0, 1'b0, 16'd0, 8'd0, 1'b1, 1'b0);
    add_tick(1'b1);
    add_tick(1'b0);
    add_tick(1'b0);
    add_tick(1'b0);
    add_check(1'b1, 1'b1, 1'b1, 16'd3, 8'd1, 1'b0, 1'b0);
    add_tick(1'b0);
    add_tick(1'b0);
    add_cfg(REG_TIMEOUT, 16'd0);
    add_tick(1'b0);
    add_check(1'b0, 1'b0, 1'b0, 16'd0, 8'd0, 1'b1, 1'b0);
    add_tick(1'b0);
    add_tick(1'b0);
    add_check(1'b1, 1'b1, 1'b1, 16'd1, 8'd2, 1'b0, 1'b0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CFG: begin
          settle();
          write_reg(directed_rows[i].addr, directed_rows[i].value);
        end
        ROW_CHECK: send_tick(directed_rows[i].value[0], 1'b1, directed_rows[i].want);
        default:   send_tick(directed_rows[i].value[0], 1'b0, '0);
      endcase
    end

    // A long on pause limit is set, but the contact stays open, so the wait ends by timeout.
    idle_on = 1'b0;
    set_regs(16'd60, 16'd0, 16'd50);
    begin
      int goal;
      goal = timeouts_predicted + 1;
      while (timeouts_predicted < goal) send_tick(pick_contact(GEN_HOLD_OPEN), 1'b0, '0);
    end

    // A long off pause with a wait limit of one.
    set_regs(16'd0, 16'd60, 16'd1);
    begin
      int goal;
      goal = timeouts_predicted + 1;
      while (timeouts_predicted < goal) send_tick(pick_contact(GEN_HOLD_OPEN), 1'b0, '0);
    end

    for (int sub = 0; sub < 8; sub++) begin
      if (sub == 0) set_regs(16'd0, 16'd0, 16'd0);
      else if (sub == 1) set_regs(16'd1, 16'd1, 16'd1);
      else set_regs(16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                    16'($urandom_range(0, 12)));
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (70) send_tick(pick_contact(GEN_NOISY), 1'b0, '0);
    end

    // Closing part without idling: complete the series and run on past its end.
    idle_on = 1'b0;
    set_regs(16'd2, 16'd3, 16'd20);
    while (!series_over) send_tick(pick_contact(GEN_CLOSE_SOON), 1'b0, '0);
    repeat (30) send_tick(1'($urandom_range(0, 1)), 1'b0, '0);

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH * 4) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: relay_response_time_tester_top.f
+incdir+design
design/rrtt_pkg.sv
design/rrtt_seq.sv
design/rrtt_avg.sv
design/relay_response_time_tester_top.sv
bench/testbench.sv
